>>> rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types and constants for the segment/box clip block.
// ----------------------------------------------------------------------------
package sbc_pkg;

	// fraction bits of the entry fraction t (Q1.30), one divider stage per bit
	localparam int QBITS = 30;
	localparam int DIV_STAGES = QBITS;

	typedef enum logic [2:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} reg_idx_t;

	// per-axis kind of entry fraction
	typedef enum logic [1:0] {
		CLS_NONE,
		CLS_ZERO,
		CLS_FULL,
		CLS_DIV
	} tcls_t;

	typedef struct packed {
		logic [2:0][31:0] mn;
		logic [2:0][31:0] mx;
	} box_t;

	// queue entry: classified segment
	typedef struct packed {
		logic [2:0][31:0] p;
		logic [2:0][31:0] q;
		logic             swap;
		logic             clip_en;
		logic             box_ok;
		tcls_t [2:0]      cls;
		logic [2:0][31:0] n;
		logic [2:0][31:0] d;
		logic [2:0][34:0] t;
		logic [2:0][32:0] off;
		logic [2:0][32:0] e;
		logic [2:0][32:0] ab;
	} q_ent_t;

	// payload carried alongside the dividers
	typedef struct packed {
		logic [2:0][31:0] p;
		logic [2:0][31:0] q;
		logic             swap;
		logic             clip_en;
		logic             box_ok;
		logic             hit;
		tcls_t [2:0]      cls;
	} pay_t;

	typedef struct packed {
		logic             hit;
		logic [2:0][31:0] o;
		logic [2:0][31:0] d;
	} res_t;

endpackage

>>> rtl/segment_box_clip.sv
// ----------------------------------------------------------------------------
// segment_box_clip
// Separating-axis test of a segment against a box, with one-end clipping.
// ----------------------------------------------------------------------------
// Usage:
//  Box bounds are written through cfg_we/cfg_idx/cfg_wdata (min x,y,z then
//  max x,y,z, Q16.16). Write them only while no transaction is in flight.
//  A segment is taken at a clock edge with start high and busy low; one
//  segment may be taken every cycle. Each transaction gives one result,
//  in order, shown for a single cycle with done high: hit and the clipped
//  end points (all zero on a miss).
//  The queue head feeds 30 divider stages (one quotient bit each, the cross
//  test runs alongside), then three registers for selection, scaling and
//  rounding; done rises with the rounded result. Throughput is one segment
//  per cycle; busy only rises if the queue fills, which the back end,
//  draining every cycle, never lets happen.
//  Reset clears the box to zero and drops everything in flight. The
//  result side cannot stall.
// ----------------------------------------------------------------------------
module segment_box_clip (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] origin_x,
	input  logic [31:0] origin_y,
	input  logic [31:0] origin_z,
	input  logic [31:0] dest_x,
	input  logic [31:0] dest_y,
	input  logic [31:0] dest_z,
	output logic        done,
	output logic        hit,
	output logic [31:0] clip_origin_x,
	output logic [31:0] clip_origin_y,
	output logic [31:0] clip_origin_z,
	output logic [31:0] clip_dest_x,
	output logic [31:0] clip_dest_y,
	output logic [31:0] clip_dest_z
);

	sbc_pkg::box_t   box_q;
	sbc_pkg::q_ent_t fe_ent, hd_ent;
	sbc_pkg::res_t   res;
	logic            push, hd_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= '0;
		end else if (cfg_we) begin
			unique case (sbc_pkg::reg_idx_t'(cfg_idx))
				sbc_pkg::REG_MIN_X: box_q.mn[0] <= cfg_wdata;
				sbc_pkg::REG_MIN_Y: box_q.mn[1] <= cfg_wdata;
				sbc_pkg::REG_MIN_Z: box_q.mn[2] <= cfg_wdata;
				sbc_pkg::REG_MAX_X: box_q.mx[0] <= cfg_wdata;
				sbc_pkg::REG_MAX_Y: box_q.mx[1] <= cfg_wdata;
				sbc_pkg::REG_MAX_Z: box_q.mx[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign push = start & ~busy;

	sbc_front u_front (
		.o   ({origin_z, origin_y, origin_x}),
		.d   ({dest_z, dest_y, dest_x}),
		.box (box_q),
		.ent (fe_ent)
	);

	sbc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_ent   (fe_ent),
		.full     (busy),
		.nonempty (hd_vld),
		.rd_ent   (hd_ent)
	);

	sbc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (hd_vld),
		.ent     (hd_ent),
		.out_vld (done),
		.res     (res)
	);

	assign hit = res.hit;
	assign clip_origin_x = res.o[0];
	assign clip_origin_y = res.o[1];
	assign clip_origin_z = res.o[2];
	assign clip_dest_x = res.d[0];
	assign clip_dest_y = res.d[1];
	assign clip_dest_z = res.d[2];

	// back end drains every cycle, so the queue never fills
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("queue filled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> clip_origin_x == 32'd0 && clip_dest_x == 32'd0
			&& clip_origin_y == 32'd0 && clip_dest_z == 32'd0)
		else $error("miss with non-zero segment");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> !$past(busy))
		else $error("result while stalled");

endmodule

>>> rtl/sbc_front.sv
// ----------------------------------------------------------------------------
// sbc_front
// Classifies a segment: box-axis test, endpoint containment, entry terms.
// ----------------------------------------------------------------------------
module sbc_front (
	input  logic [2:0][31:0] o,
	input  logic [2:0][31:0] d,
	input  sbc_pkg::box_t    box,
	output sbc_pkg::q_ent_t  ent
);

	logic signed [32:0] off, e, p33, q33, mn33, mx33, nn, dd;
	logic signed [34:0] t;
	logic        [34:0] tabs;
	logic signed [35:0] lim;
	logic        [2:0]  oin_k, din_k, sep;
	logic               oin, din;

	always_comb begin
		ent = '0;
		for (int k = 0; k < 3; k++) begin
			off = $signed({d[k][31], d[k]}) - $signed({o[k][31], o[k]});
			e = $signed({box.mx[k][31], box.mx[k]}) - $signed({box.mn[k][31], box.mn[k]});
			t = ($signed({{3{d[k][31]}}, d[k]}) + $signed({{3{o[k][31]}}, o[k]}))
				- ($signed({{3{box.mx[k][31]}}, box.mx[k]})
				+ $signed({{3{box.mn[k][31]}}, box.mn[k]}));
			tabs = t[34] ? 35'(-t) : 35'(t);
			ent.ab[k] = off[32] ? 33'(-off) : 33'(off);
			lim = $signed({3'b000, ent.ab[k]}) + $signed({{3{e[32]}}, e});
			sep[k] = $signed({1'b0, tabs}) > lim;
			ent.off[k] = off;
			ent.e[k] = e;
			ent.t[k] = t;
			oin_k[k] = $signed(o[k]) >= $signed(box.mn[k]) && $signed(o[k]) <= $signed(box.mx[k]);
			din_k[k] = $signed(d[k]) >= $signed(box.mn[k]) && $signed(d[k]) <= $signed(box.mx[k]);
		end
		oin = &oin_k;
		din = &din_k;
		ent.box_ok = ~|sep;
		ent.swap = oin;
		ent.clip_en = oin ^ din;
		ent.p = oin ? d : o;
		ent.q = oin ? o : d;
		for (int k = 0; k < 3; k++) begin
			p33 = $signed({ent.p[k][31], ent.p[k]});
			q33 = $signed({ent.q[k][31], ent.q[k]});
			mn33 = $signed({box.mn[k][31], box.mn[k]});
			mx33 = $signed({box.mx[k][31], box.mx[k]});
			nn = '0;
			dd = '0;
			ent.cls[k] = sbc_pkg::CLS_NONE;
			if (p33 < mn33) begin
				nn = mn33 - p33;
				dd = q33 - p33;
			end else if (p33 > mx33) begin
				nn = p33 - mx33;
				dd = p33 - q33;
			end
			if (p33 < mn33 || p33 > mx33) begin
				priority if (dd <= 0) ent.cls[k] = sbc_pkg::CLS_ZERO;
				else if (nn >= dd) ent.cls[k] = sbc_pkg::CLS_FULL;
				else ent.cls[k] = sbc_pkg::CLS_DIV;
			end
			ent.n[k] = nn[31:0];
			ent.d[k] = dd[31:0];
		end
	end

endmodule

>>> rtl/sbc_queue.sv
// ----------------------------------------------------------------------------
// sbc_queue
// Two-entry queue between the classifier and the back end.
// ----------------------------------------------------------------------------
module sbc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sbc_pkg::q_ent_t wr_ent,
	output logic            full,
	output logic            nonempty,
	output sbc_pkg::q_ent_t rd_ent
);

	sbc_pkg::q_ent_t ent_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      cnt_q;

	assign full = cnt_q[1];
	assign nonempty = |cnt_q;
	assign rd_ent = ent_q[rd_ptr_q];

	// back end takes the head every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (nonempty)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(nonempty);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= wr_ent;
	end

endmodule

>>> rtl/sbc_div.sv
// ----------------------------------------------------------------------------
// sbc_div
// Pipelined restoring divider: floor(n * 2^QBITS / d) for n < d.
// ----------------------------------------------------------------------------
module sbc_div (
	input  logic                     clk,
	input  logic [31:0]              n,
	input  logic [31:0]              d,
	output logic [sbc_pkg::QBITS-1:0] quo
);

	localparam int NS = sbc_pkg::DIV_STAGES;

	logic [31:0]              rem_s [NS];
	logic [31:0]              den_s [NS];
	logic [sbc_pkg::QBITS-1:0] quo_s [NS];

	for (genvar i = 0; i < NS; i++) begin : g_stage
		logic [31:0]              rin, din;
		logic [sbc_pkg::QBITS-1:0] qin;
		logic [32:0]              sh;
		logic                     ge;
		if (i == 0) begin : g_first
			assign rin = n;
			assign din = d;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_s[i-1];
			assign din = den_s[i-1];
			assign qin = quo_s[i-1];
		end
		assign sh = {rin, 1'b0};
		assign ge = sh >= {1'b0, din};
		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? 32'(sh - {1'b0, din}) : sh[31:0];
			den_s[i] <= din;
			quo_s[i] <= {qin[sbc_pkg::QBITS-2:0], ge};
		end
	end

	assign quo = quo_s[NS-1];

endmodule

>>> rtl/sbc_back.sv
// ----------------------------------------------------------------------------
// sbc_back
// Cross-axis test, entry fraction division and endpoint interpolation.
// ----------------------------------------------------------------------------
module sbc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  sbc_pkg::q_ent_t ent,
	output logic            out_vld,
	output sbc_pkg::res_t   res
);

	localparam int NS = sbc_pkg::DIV_STAGES;
	localparam logic [30:0] TONE = 31'(1) << sbc_pkg::QBITS;
	localparam logic [63:0] HALF = 64'(1) << (sbc_pkg::QBITS - 1);

	logic signed [67:0]        pa_s1 [3], pb_s1 [3], pc_s1 [3], pd_s1 [3];
	sbc_pkg::pay_t             pay_s [NS];
	sbc_pkg::pay_t             pay_hit;
	logic [NS-1:0]             vld_s;
	logic [2:0]                csep;
	logic [sbc_pkg::QBITS-1:0] quo [3];

	// cross-product axes
	for (genvar k = 0; k < 3; k++) begin : g_cross
		localparam int A = (k + 1) % 3;
		localparam int B = (k + 2) % 3;
		logic signed [69:0] lhs, rhs;
		logic        [69:0] labs;
		always_ff @(posedge clk) begin
			pa_s1[k] <= $signed(ent.t[A]) * $signed(ent.off[B]);
			pb_s1[k] <= $signed(ent.t[B]) * $signed(ent.off[A]);
			pc_s1[k] <= $signed(ent.e[A]) * $signed({1'b0, ent.ab[B]});
			pd_s1[k] <= $signed(ent.e[B]) * $signed({1'b0, ent.ab[A]});
		end
		assign lhs = 70'(pa_s1[k]) - 70'(pb_s1[k]);
		assign labs = lhs[69] ? 70'(-lhs) : 70'(lhs);
		assign rhs = 70'(pc_s1[k]) + 70'(pd_s1[k]);
		assign csep[k] = $signed(labs) > rhs;

		sbc_div u_div (
			.clk (clk),
			.n   (ent.n[k]),
			.d   (ent.d[k]),
			.quo (quo[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else
			vld_s <= {vld_s[NS-2:0], in_vld};
	end

	always_comb begin
		pay_hit = pay_s[0];
		pay_hit.hit = pay_s[0].box_ok & ~|csep;
	end

	always_ff @(posedge clk) begin
		pay_s[0].p <= ent.p;
		pay_s[0].q <= ent.q;
		pay_s[0].swap <= ent.swap;
		pay_s[0].clip_en <= ent.clip_en;
		pay_s[0].box_ok <= ent.box_ok;
		pay_s[0].hit <= 1'b0;
		pay_s[0].cls <= ent.cls;
		pay_s[1] <= pay_hit;
		for (int i = 2; i < NS; i++)
			pay_s[i] <= pay_s[i-1];
	end

	// pick the largest entry fraction
	logic [30:0]   tv [3];
	logic [30:0]   best;
	logic          any;
	logic [30:0]   best_s2;
	logic          any_s2, vld_s2;
	sbc_pkg::pay_t pay_s2;

	always_comb begin
		best = '0;
		any = 1'b0;
		for (int k = 0; k < 3; k++) begin
			unique case (pay_s[NS-1].cls[k])
				sbc_pkg::CLS_ZERO: tv[k] = '0;
				sbc_pkg::CLS_FULL: tv[k] = TONE;
				sbc_pkg::CLS_DIV:  tv[k] = {1'b0, quo[k]};
				default:           tv[k] = '0;
			endcase
			if (pay_s[NS-1].cls[k] != sbc_pkg::CLS_NONE) begin
				if (!any || tv[k] > best)
					best = tv[k];
				any = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s[NS-1];
	end

	always_ff @(posedge clk) begin
		best_s2 <= best;
		any_s2 <= any;
		pay_s2 <= pay_s[NS-1];
	end

	// scale the step
	logic [63:0]   prod_s3 [3];
	logic [2:0]    neg_s3;
	logic          any_s3, vld_s3;
	sbc_pkg::pay_t pay_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else
			vld_s3 <= vld_s2;
	end

	for (genvar k = 0; k < 3; k++) begin : g_mul
		logic signed [32:0] delta;
		logic        [32:0] mag;
		assign delta = $signed({pay_s2.q[k][31], pay_s2.q[k]})
			- $signed({pay_s2.p[k][31], pay_s2.p[k]});
		assign mag = delta[32] ? 33'(-delta) : 33'(delta);
		always_ff @(posedge clk) begin
			prod_s3[k] <= 64'(mag) * 64'(best_s2);
			neg_s3[k] <= delta[32];
		end
	end

	always_ff @(posedge clk) begin
		any_s3 <= any_s2;
		pay_s3 <= pay_s2;
	end

	// round, apply and assemble
	logic [2:0][31:0] cp;
	sbc_pkg::res_t    r;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic [63:0] step;
			step = (prod_s3[k] + HALF) >> sbc_pkg::QBITS;
			if (!any_s3)
				cp[k] = pay_s3.p[k];
			else if (neg_s3[k])
				cp[k] = pay_s3.p[k] - step[31:0];
			else
				cp[k] = pay_s3.p[k] + step[31:0];
		end
		r.hit = pay_s3.hit;
		if (!pay_s3.hit) begin
			r.o = '0;
			r.d = '0;
		end else begin
			r.o = pay_s3.swap ? pay_s3.q : pay_s3.p;
			r.d = pay_s3.swap ? pay_s3.p : pay_s3.q;
			if (pay_s3.clip_en) begin
				if (pay_s3.swap)
					r.d = cp;
				else
					r.o = cp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld <= 1'b0;
		else
			out_vld <= vld_s3;
	end

	always_ff @(posedge clk) begin
		res <= r;
	end

endmodule

>>> tb/sv/segment_box_clip_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_box_clip_tb
// Drives segments against a range of boxes (reset, ordinary, degenerate,
// inverted, full range) with random gaps between transactions. Each accepted
// segment is run through a local separating-axis and clip predictor; results
// are checked field by field and in order.
// ----------------------------------------------------------------------------
module segment_box_clip_tb;

	typedef logic signed [127:0] i128_t;

	// indexes past the last box register, which the block ignores
	localparam logic [2:0] CFG_IDX_SPARE_A = 3'd6;
	localparam logic [2:0] CFG_IDX_SPARE_B = 3'd7;
	localparam longint INT32_MIN = -64'sd2147483648;
	localparam longint INT32_MAX = 64'sd2147483647;
	localparam longint FRAC_ONE = 64'sd1 << 30;
	localparam int DRAIN_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_wdata;
	logic        start;
	logic        busy;
	logic [31:0] origin_x, origin_y, origin_z;
	logic [31:0] dest_x, dest_y, dest_z;
	logic        done;
	logic        hit;
	logic [31:0] clip_origin_x, clip_origin_y, clip_origin_z;
	logic [31:0] clip_dest_x, clip_dest_y, clip_dest_z;

	longint        box_mn[3];
	longint        box_mx[3];
	sbc_pkg::res_t pending_clips[$];
	int            fail_count;

	segment_box_clip dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint sext(input logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic longint absl(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic bit in_box(input longint p[3]);
		for (int k = 0; k < 3; k++)
			if (p[k] < box_mn[k] || p[k] > box_mx[k])
				return 1'b0;
		return 1'b1;
	endfunction

	// move outside end p towards inside end q by the largest entry fraction
	function automatic void pull_onto_box(input longint p[3], input longint q[3],
			output longint res[3]);
		longint best, n, dn, tv, delta;
		i128_t  step;
		best = -1;
		for (int k = 0; k < 3; k++) begin
			if (p[k] < box_mn[k]) begin
				n = box_mn[k] - p[k];
				dn = q[k] - p[k];
			end else if (p[k] > box_mx[k]) begin
				n = p[k] - box_mx[k];
				dn = p[k] - q[k];
			end else begin
				continue;
			end
			if (dn <= 0)
				tv = 0;
			else if (n >= dn)
				tv = FRAC_ONE;
			else
				tv = longint'((i128_t'(n) <<< 30) / i128_t'(dn));
			if (tv > best)
				best = tv;
		end
		for (int k = 0; k < 3; k++) begin
			delta = q[k] - p[k];
			if (best < 0) begin
				res[k] = p[k];
			end else begin
				step = (i128_t'(absl(delta)) * i128_t'(best) + i128_t'(FRAC_ONE / 2)) >>> 30;
				res[k] = delta < 0 ? p[k] - longint'(step) : p[k] + longint'(step);
			end
		end
	endfunction

	function automatic sbc_pkg::res_t clip_segment(input logic [2:0][31:0] org,
			input logic [2:0][31:0] dst);
		longint        o[3], d[3], off[3], ab[3], tt[3], e[3], ro[3], rd[3];
		i128_t         lhs, rhs;
		int            a, b;
		bit            oin, din;
		sbc_pkg::res_t r;
		r = '0;
		for (int k = 0; k < 3; k++) begin
			o[k] = sext(org[k]);
			d[k] = sext(dst[k]);
			off[k] = d[k] - o[k];
			ab[k] = absl(off[k]);
			tt[k] = (d[k] + o[k]) - (box_mx[k] + box_mn[k]);
			e[k] = box_mx[k] - box_mn[k];
			if (absl(tt[k]) > ab[k] + e[k])
				return r;
		end
		for (int k = 0; k < 3; k++) begin
			a = (k + 1) % 3;
			b = (k + 2) % 3;
			lhs = i128_t'(tt[a]) * i128_t'(off[b]) - i128_t'(tt[b]) * i128_t'(off[a]);
			if (lhs < 0)
				lhs = -lhs;
			rhs = i128_t'(e[a]) * i128_t'(ab[b]) + i128_t'(e[b]) * i128_t'(ab[a]);
			if (lhs > rhs)
				return r;
		end
		ro = o;
		rd = d;
		oin = in_box(o);
		din = in_box(d);
		if (oin != din) begin
			if (!oin)
				pull_onto_box(o, d, ro);
			else
				pull_onto_box(d, o, rd);
		end
		r.hit = 1'b1;
		for (int k = 0; k < 3; k++) begin
			r.o[k] = ro[k][31:0];
			r.d[k] = rd[k][31:0];
		end
		return r;
	endfunction

	// result checker: done marks a single-cycle transaction
	always @(posedge clk) begin
		sbc_pkg::res_t want;
		if (arst_n && done) begin
			if (pending_clips.size() == 0) begin
				$error("unexpected result transaction");
				fail_count++;
			end else begin
				want = pending_clips.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					fail_count++;
				end
				if (clip_origin_x !== want.o[0]) begin
					$error("clip_origin_x: expected %h, got %h", want.o[0], clip_origin_x);
					fail_count++;
				end
				if (clip_origin_y !== want.o[1]) begin
					$error("clip_origin_y: expected %h, got %h", want.o[1], clip_origin_y);
					fail_count++;
				end
				if (clip_origin_z !== want.o[2]) begin
					$error("clip_origin_z: expected %h, got %h", want.o[2], clip_origin_z);
					fail_count++;
				end
				if (clip_dest_x !== want.d[0]) begin
					$error("clip_dest_x: expected %h, got %h", want.d[0], clip_dest_x);
					fail_count++;
				end
				if (clip_dest_y !== want.d[1]) begin
					$error("clip_dest_y: expected %h, got %h", want.d[1], clip_dest_y);
					fail_count++;
				end
				if (clip_dest_z !== want.d[2]) begin
					$error("clip_dest_z: expected %h, got %h", want.d[2], clip_dest_z);
					fail_count++;
				end
			end
		end
	end

	// called at a rising edge; returns at the edge that took the transaction
	task automatic send_segment(input longint ox, oy, oz, dx, dy, dz);
		logic [2:0][31:0] org, dst;
		org = {ox[31:0], oy[31:0], oz[31:0]};
		dst = {dx[31:0], dy[31:0], dz[31:0]};
		start <= 1'b1;
		origin_x <= org[2];
		origin_y <= org[1];
		origin_z <= org[0];
		dest_x <= dst[2];
		dest_y <= dst[1];
		dest_z <= dst[0];
		do
			@(posedge clk);
		while (busy);
		// packed index 2 is x, reorder to the [0]=x layout of res_t
		pending_clips.insert(pending_clips.size(), clip_segment({org[0], org[1], org[2]},
				{dst[0], dst[1], dst[2]}));
	endtask

	task automatic pause(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic drain();
		start <= 1'b0;
		while (pending_clips.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// cfg_we goes low after each write, which keeps the enable edges apart
	task automatic write_reg(input logic [2:0] idx, input longint value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value[31:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx <= sbc_pkg::REG_MAX_Z) begin
			if (idx < sbc_pkg::REG_MAX_X)
				box_mn[2'(idx)] = sext(value[31:0]);
			else
				box_mx[2'(idx - sbc_pkg::REG_MAX_X)] = sext(value[31:0]);
		end
	endtask

	task automatic set_box(input longint mnx, mny, mnz, mxx, mxy, mxz);
		drain();
		write_reg(sbc_pkg::REG_MIN_X, mnx);
		write_reg(sbc_pkg::REG_MIN_Y, mny);
		write_reg(sbc_pkg::REG_MIN_Z, mnz);
		write_reg(sbc_pkg::REG_MAX_X, mxx);
		write_reg(sbc_pkg::REG_MAX_Y, mxy);
		write_reg(sbc_pkg::REG_MAX_Z, mxz);
	endtask

	function automatic longint clamp32(input longint v);
		return v < INT32_MIN ? INT32_MIN : (v > INT32_MAX ? INT32_MAX : v);
	endfunction

	function automatic longint pick(input longint lo, input longint hi);
		longint t;
		longint unsigned span;
		lo = clamp32(lo);
		hi = clamp32(hi);
		if (hi < lo) begin
			t = lo;
			lo = hi;
			hi = t;
		end
		span = longint'(hi - lo) + 1;
		return lo + longint'({$urandom, $urandom} % span);
	endfunction

	// coordinate near the box on one axis: inside, just outside or far
	function automatic longint near_coord(input int k, input bit inner);
		longint lo, hi, ext, m;
		lo = box_mn[k] < box_mx[k] ? box_mn[k] : box_mx[k];
		hi = box_mn[k] < box_mx[k] ? box_mx[k] : box_mn[k];
		if (inner)
			return pick(lo, hi);
		ext = hi - lo + 1;
		case ($urandom_range(0, 3))
			0: m = 2;
			1: m = ext / 4 + 1;
			2: m = ext;
			default: m = ext * 8;
		endcase
		return pick(lo - m, hi + m);
	endfunction

	function automatic longint full_coord();
		case ($urandom_range(0, 7))
			0: return INT32_MIN;
			1: return INT32_MAX;
			default: return sext($urandom);
		endcase
	endfunction

	task automatic random_segment(input bit gaps);
		longint p[6];
		int     kind;
		bit     o_in, d_in;
		kind = $urandom_range(0, 19);
		o_in = $urandom_range(0, 1);
		d_in = $urandom_range(0, 1);
		for (int k = 0; k < 3; k++) begin
			if (kind < 13) begin
				p[k] = near_coord(k, o_in);
				p[3 + k] = near_coord(k, d_in);
			end else if (kind < 16) begin
				p[k] = near_coord(k, 1'b1);
				p[3 + k] = full_coord();
			end else if (kind < 18) begin
				p[k] = full_coord();
				p[3 + k] = full_coord();
			end else begin
				// degenerate: point segment or axis-parallel segment
				p[k] = near_coord(k, $urandom_range(0, 1));
				p[3 + k] = (kind == 18 || k != 0) ? p[k] : near_coord(k, 1'b0);
			end
		end
		if ($urandom_range(0, 1))
			send_segment(p[0], p[1], p[2], p[3], p[4], p[5]);
		else
			send_segment(p[3], p[4], p[5], p[0], p[1], p[2]);
		if (gaps)
			pause(random_gap());
	endtask

	task automatic test_reset_box();
		// box collapsed to the origin point
		send_segment(0, 0, 0, 0, 0, 0);
		send_segment(-65536, 0, 0, 65536, 0, 0);
		send_segment(-65536, 1, 0, 65536, 1, 0);
		send_segment(INT32_MIN, INT32_MIN, INT32_MIN, INT32_MAX, INT32_MAX, INT32_MAX);
		pause(2);
	endtask

	task automatic test_directed();
		set_box(-65536, -65536, -65536, 65536, 65536, 65536);
		send_segment(0, 0, 0, 32768, 32768, 32768);           // both inside
		send_segment(-262144, 0, 0, 0, 0, 0);                 // origin outside
		send_segment(0, 0, 0, 0, 262144, 0);                  // dest outside
		send_segment(-262144, -262144, 0, 0, 0, 0);           // tie on x and y
		send_segment(-131072, -196608, 65536, 1, 2, 3);       // largest fraction on y
		send_segment(-262144, 0, 0, 262144, 0, 0);            // both outside, crossing
		send_segment(131072, 131072, 131072, 262144, 0, 0);   // miss
		send_segment(131072, 0, 0, 0, 131072, 0);             // touches a box edge
		send_segment(65536, 65536, 65536, INT32_MAX, INT32_MAX, INT32_MAX);
		send_segment(INT32_MIN, 0, 0, 65536, 0, 0);           // outside end on the face
		send_segment(INT32_MIN, INT32_MIN, INT32_MIN, 0, 0, 0);
		send_segment(INT32_MAX, INT32_MIN, INT32_MAX, 7, -7, 3);
		pause(1);
		// box bounds outside the index range are ignored
		drain();
		write_reg(CFG_IDX_SPARE_A, 32'h1234_5678);
		write_reg(CFG_IDX_SPARE_B, INT32_MIN);
		send_segment(0, 0, 0, 0, 0, 262144);
	endtask

	task automatic test_inverted_box();
		set_box(65536, 0, 0, -65536, 65536, 65536);
		send_segment(0, 32768, 32768, 0, 32768, 32768);
		send_segment(-131072, 32768, 32768, 131072, 32768, 32768);
		send_segment(0, -131072, 32768, 0, 131072, 32768);
		send_segment(INT32_MAX, INT32_MAX, INT32_MAX, INT32_MIN, INT32_MIN, INT32_MIN);
		repeat (60) random_segment(1'b1);
	endtask

	task automatic test_full_range_box();
		set_box(INT32_MIN, INT32_MIN, INT32_MIN, INT32_MAX, INT32_MAX, INT32_MAX);
		send_segment(INT32_MIN, INT32_MIN, INT32_MIN, INT32_MAX, INT32_MAX, INT32_MAX);
		send_segment(INT32_MAX, INT32_MIN, 0, INT32_MIN, INT32_MAX, 0);
		repeat (40) random_segment(1'b1);
		// narrow box on the extremes: long segments, large denominators
		set_box(INT32_MAX - 3, INT32_MIN, INT32_MIN, INT32_MAX, INT32_MIN + 5, INT32_MAX);
		send_segment(INT32_MIN, INT32_MAX, 0, INT32_MAX, INT32_MIN, 0);
		repeat (60) random_segment(1'b1);
	endtask

	task automatic test_random_boxes();
		longint c, h;
		longint mn[3], mx[3];
		for (int phase = 0; phase < 6; phase++) begin
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(0, 3))
					0: h = $urandom_range(0, 16);
					1: h = $urandom_range(0, 1 << 20);
					2: h = $urandom_range(0, 1 << 28);
					default: h = $urandom_range(0, INT32_MAX);
				endcase
				c = sext($urandom);
				mn[k] = clamp32(c - h);
				mx[k] = clamp32(c + h);
			end
			set_box(mn[0], mn[1], mn[2], mx[0], mx[1], mx[2]);
			// back-to-back stretch, then gaps
			repeat (40) random_segment(1'b0);
			repeat (190) random_segment(1'b1);
		end
	endtask

	task automatic test_pause_until_empty();
		repeat (20) random_segment(1'b0);
		drain();
		repeat (20) random_segment(1'b1);
	endtask

	initial begin
		fail_count = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		start = 1'b0;
		{origin_x, origin_y, origin_z, dest_x, dest_y, dest_z} = '0;
		for (int k = 0; k < 3; k++) begin
			box_mn[k] = 0;
			box_mx[k] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_box();
		test_directed();
		test_inverted_box();
		test_full_range_box();
		test_random_boxes();
		test_pause_until_empty();
		drain();

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#50ms;
		$display("tb: failure");
		$finish;
	end

endmodule
